// File: rtl/pcdg_pkg.sv
// Shared widths, codes and types of the periodic central-difference gradient unit.
package pcdg_pkg;

  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned MAX_COLS  = 64;
  localparam int unsigned ROW_W     = $clog2(MAX_ROWS);
  localparam int unsigned COL_W     = $clog2(MAX_COLS);
  localparam int unsigned ADDR_W    = ROW_W + COL_W;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned GRID_W    = 7;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned GRAD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIFF_W    = SAMPLE_W + 1;
  localparam int unsigned PROD_W    = DIFF_W + SCALE_W + 1;

  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration port (byte address is four times the index).
  localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
  localparam logic [1:0] REG_GRID_COLS  = 2'd1;
  localparam logic [1:0] REG_SCALE_ROWS = 2'd2;
  localparam logic [1:0] REG_SCALE_COLS = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One classified command as it travels from the front end to the back end.
  typedef struct packed {
    kind_e               kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row_prev;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_prev;
    logic [COL_W-1:0]    col_next;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_rows;
    logic [SCALE_W-1:0] scale_cols;
  } scale_t;

endpackage

// File: rtl/pcdg_front.sv
// Front end: configuration registers, command acceptance and neighbor index classification.
module pcdg_front import pcdg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  input  logic                start_i,
  input  logic                cmd_i,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [COL_W-1:0]    col_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                full_i,
  output logic                push_o,
  output item_t               item_o,
  output scale_t              scale_o
);

  logic [GRID_W-1:0]  grid_rows_q;
  logic [GRID_W-1:0]  grid_cols_q;
  logic [SCALE_W-1:0] scale_rows_q;
  logic [SCALE_W-1:0] scale_cols_q;
  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [GRID_W-1:0]  n_rows;
  logic [GRID_W-1:0]  n_cols;
  logic [ROW_W-1:0]   last_row;
  logic [COL_W-1:0]   last_col;
  logic               in_range;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= GRID_W'(MAX_ROWS);
      grid_cols_q  <= GRID_W'(MAX_COLS);
      scale_rows_q <= SCALE_W'(1 << FRAC_W);
      scale_cols_q <= SCALE_W'(1 << FRAC_W);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_ROWS:  grid_rows_q  <= pwdata[GRID_W-1:0];
        REG_GRID_COLS:  grid_cols_q  <= pwdata[GRID_W-1:0];
        REG_SCALE_ROWS: scale_rows_q <= pwdata[SCALE_W-1:0];
        REG_SCALE_COLS: scale_cols_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_ROWS:  prdata = APB_DW'(grid_rows_q);
      REG_GRID_COLS:  prdata = APB_DW'(grid_cols_q);
      REG_SCALE_ROWS: prdata = APB_DW'(scale_rows_q);
      REG_SCALE_COLS: prdata = APB_DW'(scale_cols_q);
      default:        prdata = '0;
    endcase
  end

  // A size of zero behaves as one, a size above the grid as the full grid.
  always_comb begin
    if (grid_rows_q == '0) begin
      n_rows = GRID_W'(1);
    end else if (grid_rows_q > GRID_W'(MAX_ROWS)) begin
      n_rows = GRID_W'(MAX_ROWS);
    end else begin
      n_rows = grid_rows_q;
    end
    if (grid_cols_q == '0) begin
      n_cols = GRID_W'(1);
    end else if (grid_cols_q > GRID_W'(MAX_COLS)) begin
      n_cols = GRID_W'(MAX_COLS);
    end else begin
      n_cols = grid_cols_q;
    end
  end

  assign last_row = ROW_W'(n_rows - GRID_W'(1));
  assign last_col = COL_W'(n_cols - GRID_W'(1));
  assign in_range = (GRID_W'(row_i) < n_rows) && (GRID_W'(col_i) < n_cols);

  always_comb begin
    item_o.row      = row_i;
    item_o.col      = col_i;
    item_o.sample   = sample_i;
    item_o.row_prev = (row_i == '0) ? last_row : row_i - ROW_W'(1);
    item_o.row_next = (row_i == last_row) ? '0 : row_i + ROW_W'(1);
    item_o.col_prev = (col_i == '0) ? last_col : col_i - COL_W'(1);
    item_o.col_next = (col_i == last_col) ? '0 : col_i + COL_W'(1);
    if (!in_range) begin
      item_o.kind = KIND_ERROR;
    end else if (cmd_i == CMD_READ) begin
      item_o.kind = KIND_READ;
    end else begin
      item_o.kind = KIND_WRITE;
    end
  end

  assign push_o             = start_i & ~full_i;
  assign scale_o.scale_rows = scale_rows_q;
  assign scale_o.scale_cols = scale_cols_q;

endmodule

// File: rtl/pcdg_queue.sv
// Short queue of classified commands between the front end and the back end.
module pcdg_queue import pcdg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue fill count lost a push");
`endif

endmodule

// File: rtl/pcdg_back.sv
// Back end: sample memory, neighbor fetch sequence, scaling multiplier and result register.
module pcdg_back import pcdg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  item_t             head_i,
  output logic              pop_o,
  input  scale_t            scale_i,
  output logic              done_o,
  output logic [GRAD_W-1:0] grad_rows_o,
  output logic [GRAD_W-1:0] grad_cols_o,
  output logic              status_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_RD3  = 7'b0001000,
    S_RD4  = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  logic [SAMPLE_W-1:0]      sample_mem_q [MEM_DEPTH];
  logic [SAMPLE_W-1:0]      rdata_q;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_addr;
  logic signed [SAMPLE_W-1:0] near_q;
  logic signed [DIFF_W-1:0] dr_q;
  logic signed [DIFF_W-1:0] dc_q;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [SCALE_W:0]  mul_b;
  logic signed [PROD_W-1:0] product;
  logic signed [PROD_W-1:0] prod_r_q;
  logic signed [PROD_W-1:0] prod_c_q;
  logic                     done_q, done_d;
  logic                     status_q, status_d;
  logic [GRAD_W-1:0]        grad_rows_q, grad_rows_d;
  logic [GRAD_W-1:0]        grad_cols_q, grad_cols_d;

  // Floor shift by the fraction width, then clamp to the signed result range.
  function automatic logic [GRAD_W-1:0] shift_sat(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-FRAC_W-1:0] q;
    q = p[PROD_W-1:FRAC_W];
    if (q[PROD_W-FRAC_W-1:GRAD_W-1] == '0 || q[PROD_W-FRAC_W-1:GRAD_W-1] == '1) begin
      return q[GRAD_W-1:0];
    end else if (q[PROD_W-FRAC_W-1]) begin
      return {1'b1, {(GRAD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(GRAD_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sample_mem_q[mem_addr] <= head_i.sample;
    end
    rdata_q <= sample_mem_q[mem_addr];
  end

  assign diff    = DIFF_W'(near_q) - DIFF_W'($signed(rdata_q));
  assign mul_a   = (state_q == S_MUL) ? dc_q : dr_q;
  assign mul_b   = (state_q == S_MUL) ? $signed({1'b0, scale_i.scale_cols})
                                      : $signed({1'b0, scale_i.scale_rows});
  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_d     = state_q;
    mem_we      = 1'b0;
    mem_addr    = {head_i.row_next, head_i.col};
    pop_o       = 1'b0;
    done_d      = 1'b0;
    status_d    = status_q;
    grad_rows_d = grad_rows_q;
    grad_cols_d = grad_cols_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            KIND_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = {head_i.row, head_i.col};
              pop_o    = 1'b1;
            end
            KIND_READ: begin
              state_d = S_RD1;
            end
            default: begin
              pop_o       = 1'b1;
              done_d      = 1'b1;
              status_d    = STATUS_RANGE;
              grad_rows_d = '0;
              grad_cols_d = '0;
            end
          endcase
        end
      end
      S_RD1: begin
        mem_addr = {head_i.row_prev, head_i.col};
        state_d  = S_RD2;
      end
      S_RD2: begin
        mem_addr = {head_i.row, head_i.col_next};
        state_d  = S_RD3;
      end
      S_RD3: begin
        mem_addr = {head_i.row, head_i.col_prev};
        state_d  = S_RD4;
      end
      S_RD4: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        pop_o       = 1'b1;
        done_d      = 1'b1;
        status_d    = STATUS_OK;
        grad_rows_d = shift_sat(prod_r_q);
        grad_cols_d = shift_sat(prod_c_q);
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD1 || state_q == S_RD3) begin
      near_q <= rdata_q;
    end
    if (state_q == S_RD2) begin
      dr_q <= diff;
    end
    if (state_q == S_RD4) begin
      dc_q <= diff;
    end
    if (state_q == S_RD3) begin
      prod_r_q <= product;
    end
    if (state_q == S_MUL) begin
      prod_c_q <= product;
    end
    status_q    <= status_d;
    grad_rows_q <= grad_rows_d;
    grad_cols_q <= grad_cols_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign grad_rows_o = grad_rows_q;
  assign grad_cols_o = grad_cols_q;

`ifndef SYNTH
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_OUT || $past(state_q) == S_IDLE))
    else $error("result beat raised outside idle or output step");

  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !empty_i && head_i.kind == KIND_READ) |=> (state_q == S_RD1))
    else $error("read command did not start the fetch sequence");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("back end retired a command from an empty queue");
`endif

endmodule

// File: rtl/periodic_central_difference_gradient_unit.sv
// Top level of the periodic central-difference gradient unit.
//
// Usage: a command beat is taken at a rising edge where start is high and busy is low.
// cmd_i selects a sample write or a gradient read of the cell at row_i, col_i; sample_i
// is used by writes only. Results leave on grad_rows_o, grad_cols_o and status_o, each
// beat marked by done_o for exactly one cycle; the receiver cannot stall, so every
// result must be taken in the cycle it appears.
// A write in range produces no result. Any command whose index lies outside the grid in
// use produces one result with status 1 and zero gradients. A read in range produces the
// two saturated, scaled wraparound differences with status 0.
// The front end classifies a command in the cycle it is accepted and places it in a
// two-entry queue; busy is high only while that queue is full. The back end retires a
// write or an out-of-range command straight from its idle state; a read runs four
// fetches on the single-ported sample memory, a step to form the column difference, a
// column pass through the shared multiplier (the row pass overlaps the last fetch) and
// a saturation step. With the queue empty, an out-of-range result passes the queue slot
// and the result register on its way out; a read result also passes the read sequence.
// Reset clears the queue, the sequencer and the configuration registers (64 by 64 grid,
// unit scales). The sample memory is not cleared; cells must be written before they are
// read. Configuration writes on the APB port are taken in any cycle, pready is always high.
module periodic_central_difference_gradient_unit import pcdg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [COL_W-1:0]    col_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                done_o,
  output logic [GRAD_W-1:0]   grad_rows_o,
  output logic [GRAD_W-1:0]   grad_cols_o,
  output logic                status_o
);

  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  item_t  q_item;
  item_t  q_head;
  scale_t scale;

  // Writes complete in their access cycle, so the port never inserts wait states.
  assign pready = 1'b1;
  assign busy   = q_full;

  pcdg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .start_i  (start),
    .cmd_i    (cmd_i),
    .row_i    (row_i),
    .col_i    (col_i),
    .sample_i (sample_i),
    .full_i   (q_full),
    .push_o   (q_push),
    .item_o   (q_item),
    .scale_o  (scale)
  );

  // The queue decouples command acceptance from the multi-cycle memory sequence.
  pcdg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  pcdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .scale_i     (scale),
    .done_o      (done_o),
    .grad_rows_o (grad_rows_o),
    .grad_cols_o (grad_cols_o),
    .status_o    (status_o)
  );

endmodule
